@@ hw/rtl/baro_temp_pressure_compensation_top_macros.svh @@
// assertion macros for the compensation block
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BTPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("btpc assertion failed");
`define BTPC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("btpc assertion failed");
`else
`define BTPC_ASSERT(lbl, prop)
`define BTPC_ASSERT_RST(lbl, prop)
`endif

`endif

@@ hw/rtl/btpc_pkg.sv @@
package btpc_pkg;

  localparam int unsigned NumCfg       = 5;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgW         = 32;
  localparam int unsigned FifoDepthDef = 4;

  localparam int TOffset = 4000;
  localparam int B4Bias  = 32768;
  localparam int B7Scale = 50000;
  localparam int PC1     = 3038;
  localparam int PC2     = 7357;
  localparam int PC3     = 3791;
  localparam int PMax    = 262143;
  localparam int TMax    = 32767;
  localparam int TMin    = -32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AC1_AC2 = 3'd0,
    CFG_AC3_AC4 = 3'd1,
    CFG_AC5_AC6 = 3'd2,
    CFG_B1_B2   = 3'd3,
    CFG_MC_MD   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;
  } item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic               divide_error;
  } result_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } cal_t;

  typedef struct packed {
    logic signed [17:0] x1;
    logic signed [18:0] den;
    logic [15:0]        up;
    logic               zero_div;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_word_t;

endpackage

@@ hw/rtl/btpc_front.sv @@
module btpc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  btpc_pkg::item_t   item_i,
  input  btpc_pkg::cal_t    cal_i,
  output btpc_pkg::job_word_t push_o
);

  logic                f1_vld_q;
  btpc_pkg::item_t     f1_item_q;
  logic                f2_vld_q;
  logic signed [33:0]  f2_prod_q;
  logic [15:0]         f2_up_q;

  logic signed [16:0]  diff;
  logic signed [33:0]  prod_d;
  logic signed [33:0]  prod_adj;
  logic signed [17:0]  x1;
  logic signed [18:0]  den;

  always_comb begin
    diff   = $signed({1'b0, f1_item_q.raw_temperature}) - $signed({1'b0, cal_i.ac6});
    prod_d = 34'(diff) * 34'($signed({1'b0, cal_i.ac5}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else begin
      f1_vld_q <= accept_i;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      f1_item_q <= item_i;
    end
    f2_prod_q <= prod_d;
    f2_up_q   <= f1_item_q.raw_pressure;
  end

  // truncate toward zero on the divide by 32768
  always_comb begin
    prod_adj = f2_prod_q + $signed({19'b0, {15{f2_prod_q[33]}}});
    x1       = prod_adj[32:15];
    den      = 19'(x1) + 19'(cal_i.md);
    push_o.valid        = f2_vld_q;
    push_o.job.x1       = x1;
    push_o.job.den      = den;
    push_o.job.up       = f2_up_q;
    push_o.job.zero_div = (den == '0);
  end

endmodule

@@ hw/rtl/btpc_fifo.sv @@
`include "baro_temp_pressure_compensation_top_macros.svh"

module btpc_fifo #(
  parameter int unsigned DEPTH = btpc_pkg::FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btpc_pkg::job_word_t push_i,
  output btpc_pkg::job_word_t pop_o,
  output logic                busy_o
);

  localparam int unsigned PtrW      = $clog2(DEPTH);
  localparam int unsigned CntW      = $clog2(DEPTH + 1);
  localparam int unsigned BusyLevel = DEPTH - 2;

  btpc_pkg::job_t    mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;

  assign pop = (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i.valid && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i.valid && pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  assign pop_o.valid = pop;
  assign pop_o.job   = mem_q[rd_ptr_q];
  assign busy_o      = (count_q >= CntW'(BusyLevel));

  `BTPC_ASSERT(a_no_overflow, push_i.valid |-> (count_q != CntW'(DEPTH)))
  `BTPC_ASSERT(a_push_seen, (count_q == '0 && push_i.valid) |=> pop_o.valid)
  `BTPC_ASSERT(a_busy_by_push, $rose(busy_o) |-> $past(push_i.valid))

endmodule

@@ hw/rtl/btpc_div.sv @@
module btpc_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 17,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             vld_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned AccW = DEN_W + NUM_W;

  logic             vld_q [NUM_W];
  logic [AccW-1:0]  acc_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             vld_in;
    logic [AccW-1:0]  acc_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [AccW:0]    sh;
    logic [DEN_W:0]   top;
    logic [DEN_W:0]   top_sub;
    logic             fit;

    if (i == 0) begin : g_first
      assign vld_in = vld_i;
      assign acc_in = {{DEN_W{1'b0}}, num_i};
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[i-1];
      assign acc_in = acc_q[i-1];
      assign den_in = den_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    assign sh      = {acc_in, 1'b0};
    assign top     = sh[AccW -: (DEN_W + 1)];
    assign top_sub = top - {1'b0, den_in};
    assign fit     = (top >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[i] <= fit ? {top_sub[DEN_W-1:0], sh[NUM_W-1:1], 1'b1} : sh[AccW-1:0];
      den_q[i] <= den_in;
      tag_q[i] <= tag_in;
    end
  end

  assign vld_o  = vld_q[NUM_W-1];
  assign quot_o = acc_q[NUM_W-1][NUM_W-1:0];
  assign tag_o  = tag_q[NUM_W-1];

endmodule

@@ hw/rtl/btpc_back.sv @@
module btpc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btpc_pkg::cal_t      cal_i,
  input  btpc_pkg::job_word_t pop_i,
  output logic                res_vld_o,
  output btpc_pkg::result_t   res_o
);

  localparam int unsigned Tag1W = 36;
  localparam int unsigned Tag2W = 18;

  // valid chain
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic v11_q, v12_q, v13_q, v14_q, v15_q;
  logic d1_vld, d2_vld;

  // b0
  logic signed [17:0] x1_0_q;
  logic signed [18:0] den_0_q;
  logic [15:0]        up_0_q;
  logic               zd_0_q;
  logic [15:0]        mc_abs;
  logic [17:0]        den_abs;
  logic               qneg;
  logic [Tag1W-1:0]   tag1_in, tag1_out;
  logic [26:0]        quot1;

  // b1
  logic signed [17:0] x1_d1;
  logic [15:0]        up_d1;
  logic               zd_d1, qneg_d1;
  logic signed [27:0] q1s, x2_d1;
  logic signed [28:0] b5_1_q, b6_1_q;
  logic [15:0]        up_1_q;
  logic               zd_1_q;

  // b2
  logic [27:0]        b6_abs;
  logic signed [29:0] tsum, tadj, tq;
  logic signed [15:0] t_d2;
  logic [55:0]        sq_2_q;
  logic signed [44:0] a2p_2_q, a3p_2_q;
  logic signed [15:0] t_2_q;
  logic [15:0]        up_2_q;
  logic               zd_2_q;

  // b3
  logic [43:0]        s44;
  logic signed [44:0] a2p_adj, a3p_adj;
  logic signed [48:0] p2lo_3_q, p1lo_3_q;
  logic signed [28:0] p2hi_3_q, p1hi_3_q;
  logic signed [33:0] x2a_3_q;
  logic signed [31:0] x1b_3_q;
  logic signed [15:0] t_3_q;
  logic [15:0]        up_3_q;
  logic               zd_3_q;

  // b4
  logic signed [61:0] pb2_4_q, pb1_4_q;
  logic signed [33:0] x2a_4_q;
  logic signed [31:0] x1b_4_q;
  logic signed [15:0] t_4_q;
  logic [15:0]        up_4_q;
  logic               zd_4_q;

  // b5
  logic signed [61:0] pb2_adj, pb1_adj;
  logic signed [50:0] x1a_5_q;
  logic signed [45:0] x2b_5_q;
  logic signed [33:0] x2a_5_q;
  logic signed [31:0] x1b_5_q;
  logic signed [15:0] t_5_q;
  logic [15:0]        up_5_q;
  logic               zd_5_q;

  // b6
  logic signed [52:0] b3n_6_q;
  logic signed [46:0] x3s_6_q;
  logic signed [15:0] t_6_q;
  logic [15:0]        up_6_q;
  logic               zd_6_q;

  // b7
  logic signed [52:0] b3n_adj, b3q;
  logic signed [46:0] x3s_adj, x3q;
  logic [31:0]        b3_7_q, v_7_q;
  logic signed [15:0] t_7_q;
  logic [15:0]        up_7_q;
  logic               zd_7_q;

  // b8
  logic [31:0]        b4p_8_q, b7d_8_q;
  logic signed [15:0] t_8_q;
  logic               zd_8_q;

  // b9
  logic [16:0]        b4_d9;
  logic [16:0]        b4_9_q;
  logic [31:0]        b7_9_q;
  logic signed [15:0] t_9_q;
  logic               zd_9_q;
  logic [31:0]        num2;
  logic [Tag2W-1:0]   tag2_in, tag2_out;
  logic [31:0]        quot2;

  // b11 to b15
  logic [31:0]        q_d11, q_11_q;
  logic signed [15:0] t_11_q, t_12_q, t_13_q, t_14_q;
  logic               zd_11_q, zd_12_q, zd_13_q, zd_14_q;
  logic [18:0]        p19_12_q, p19_13_q, p19_14_q;
  logic               big_12_q, big_13_q, big_14_q;
  logic [21:0]        sq2_12_q;
  logic [31:0]        m2_12_q;
  logic [33:0]        prod13;
  logic [17:0]        x1c_13_q;
  logic [15:0]        x2c_13_q;
  logic signed [19:0] corr_14_q;
  logic signed [19:0] cadj, cq;
  logic signed [20:0] pn;
  logic [17:0]        p_fin;
  btpc_pkg::result_t  res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0;
      v11_q <= 1'b0; v12_q <= 1'b0; v13_q <= 1'b0; v14_q <= 1'b0; v15_q <= 1'b0;
    end else begin
      v0_q <= pop_i.valid; v1_q <= d1_vld; v2_q <= v1_q; v3_q <= v2_q;
      v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
      v9_q <= v8_q; v11_q <= d2_vld; v12_q <= v11_q; v13_q <= v12_q;
      v14_q <= v13_q; v15_q <= v14_q;
    end
  end

  // temperature divide: mc * 2048 / (x1 + md)
  always_comb begin
    mc_abs  = cal_i.mc[15] ? 16'(-cal_i.mc) : cal_i.mc;
    den_abs = den_0_q[18] ? 18'(-den_0_q) : den_0_q[17:0];
    qneg    = cal_i.mc[15] ^ den_0_q[18];
    tag1_in = {x1_0_q, up_0_q, zd_0_q, qneg};
  end

  btpc_div #(
    .NUM_W (27),
    .DEN_W (18),
    .TAG_W (Tag1W)
  ) u_div_t (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v0_q),
    .num_i  ({mc_abs, 11'b0}),
    .den_i  (den_abs),
    .tag_i  (tag1_in),
    .vld_o  (d1_vld),
    .quot_o (quot1),
    .tag_o  (tag1_out)
  );

  always_comb begin
    x1_d1   = $signed(tag1_out[35:18]);
    up_d1   = tag1_out[17:2];
    zd_d1   = tag1_out[1];
    qneg_d1 = tag1_out[0];
    q1s     = $signed({1'b0, quot1});
    x2_d1   = qneg_d1 ? -q1s : q1s;
  end

  // temperature and squared b6
  always_comb begin
    b6_abs = b6_1_q[28] ? 28'(-b6_1_q) : 28'(b6_1_q);
    tsum   = 30'(b5_1_q) + 30'sd8;
    tadj   = tsum + $signed({26'b0, {4{tsum[29]}}});
    tq     = tadj >>> 4;
    if (tq > 30'(btpc_pkg::TMax)) begin
      t_d2 = 16'(btpc_pkg::TMax);
    end else if (tq < 30'(btpc_pkg::TMin)) begin
      t_d2 = 16'(btpc_pkg::TMin);
    end else begin
      t_d2 = 16'(tq);
    end
  end

  always_comb begin
    s44     = sq_2_q[55:12];
    a2p_adj = a2p_2_q + $signed({34'b0, {11{a2p_2_q[44]}}});
    a3p_adj = a3p_2_q + $signed({32'b0, {13{a3p_2_q[44]}}});
    pb2_adj = pb2_4_q + $signed({51'b0, {11{pb2_4_q[61]}}});
    pb1_adj = pb1_4_q + $signed({46'b0, {16{pb1_4_q[61]}}});
    b3n_adj = b3n_6_q + $signed({51'b0, {2{b3n_6_q[52]}}});
    b3q     = b3n_adj >>> 2;
    x3s_adj = x3s_6_q + $signed({45'b0, {2{x3s_6_q[46]}}});
    x3q     = x3s_adj >>> 2;
    b4_d9   = b4p_8_q[31:15];
    num2    = b7_9_q[31] ? b7_9_q : {b7_9_q[30:0], 1'b0};
    tag2_in = {t_9_q, zd_9_q, b7_9_q[31]};
  end

  always_ff @(posedge clk_i) begin
    x1_0_q  <= pop_i.job.x1;
    den_0_q <= pop_i.job.den;
    up_0_q  <= pop_i.job.up;
    zd_0_q  <= pop_i.job.zero_div;

    b5_1_q <= 29'(x1_d1) + 29'(x2_d1);
    b6_1_q <= 29'(x1_d1) + 29'(x2_d1) - 29'(btpc_pkg::TOffset);
    up_1_q <= up_d1;
    zd_1_q <= zd_d1;

    sq_2_q  <= b6_abs * b6_abs;
    a2p_2_q <= 45'(cal_i.ac2) * 45'(b6_1_q);
    a3p_2_q <= 45'(cal_i.ac3) * 45'(b6_1_q);
    t_2_q   <= t_d2;
    up_2_q  <= up_1_q;
    zd_2_q  <= zd_1_q;

    p2lo_3_q <= 49'(cal_i.b2) * $signed({17'b0, s44[31:0]});
    p2hi_3_q <= 29'(cal_i.b2) * $signed({17'b0, s44[43:32]});
    p1lo_3_q <= 49'(cal_i.b1) * $signed({17'b0, s44[31:0]});
    p1hi_3_q <= 29'(cal_i.b1) * $signed({17'b0, s44[43:32]});
    x2a_3_q  <= 34'(a2p_adj >>> 11);
    x1b_3_q  <= 32'(a3p_adj >>> 13);
    t_3_q    <= t_2_q;
    up_3_q   <= up_2_q;
    zd_3_q   <= zd_2_q;

    pb2_4_q <= (62'(p2hi_3_q) <<< 32) + 62'(p2lo_3_q);
    pb1_4_q <= (62'(p1hi_3_q) <<< 32) + 62'(p1lo_3_q);
    x2a_4_q <= x2a_3_q;
    x1b_4_q <= x1b_3_q;
    t_4_q   <= t_3_q;
    up_4_q  <= up_3_q;
    zd_4_q  <= zd_3_q;

    x1a_5_q <= 51'(pb2_adj >>> 11);
    x2b_5_q <= 46'(pb1_adj >>> 16);
    x2a_5_q <= x2a_4_q;
    x1b_5_q <= x1b_4_q;
    t_5_q   <= t_4_q;
    up_5_q  <= up_4_q;
    zd_5_q  <= zd_4_q;

    b3n_6_q <= (53'(cal_i.ac1) <<< 2) + 53'(x1a_5_q) + 53'(x2a_5_q) + 53'sd2;
    x3s_6_q <= 47'(x1b_5_q) + 47'(x2b_5_q) + 47'sd2;
    t_6_q   <= t_5_q;
    up_6_q  <= up_5_q;
    zd_6_q  <= zd_5_q;

    b3_7_q <= b3q[31:0];
    v_7_q  <= x3q[31:0] + 32'(btpc_pkg::B4Bias);
    t_7_q  <= t_6_q;
    up_7_q <= up_6_q;
    zd_7_q <= zd_6_q;

    b4p_8_q <= cal_i.ac4 * v_7_q;
    b7d_8_q <= {16'b0, up_7_q} - b3_7_q;
    t_8_q   <= t_7_q;
    zd_8_q  <= zd_7_q;

    b4_9_q <= b4_d9;
    b7_9_q <= b7d_8_q * 32'(btpc_pkg::B7Scale);
    t_9_q  <= t_8_q;
    zd_9_q <= zd_8_q | (b4_d9 == '0);
  end

  btpc_div #(
    .NUM_W (32),
    .DEN_W (17),
    .TAG_W (Tag2W)
  ) u_div_p (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v9_q),
    .num_i  (num2),
    .den_i  (b4_9_q),
    .tag_i  (tag2_in),
    .vld_o  (d2_vld),
    .quot_o (quot2),
    .tag_o  (tag2_out)
  );

  // pressure correction and clamp to 0..PMax; a quotient large enough clamps the result at the top
  always_comb begin
    q_d11  = tag2_out[0] ? {quot2[30:0], 1'b0} : quot2;
    prod13 = sq2_12_q * 12'(btpc_pkg::PC1);
    cadj   = corr_14_q + $signed({16'b0, {4{corr_14_q[19]}}});
    cq     = cadj >>> 4;
    pn     = $signed({2'b0, p19_14_q}) + 21'(cq);
    if (big_14_q) begin
      p_fin = 18'(btpc_pkg::PMax);
    end else if (pn < 21'sd0) begin
      p_fin = '0;
    end else if (pn > 21'(btpc_pkg::PMax)) begin
      p_fin = 18'(btpc_pkg::PMax);
    end else begin
      p_fin = pn[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    q_11_q  <= q_d11;
    t_11_q  <= $signed(tag2_out[17:2]);
    zd_11_q <= tag2_out[1];

    big_12_q <= |q_11_q[31:19];
    p19_12_q <= q_11_q[18:0];
    sq2_12_q <= q_11_q[18:8] * q_11_q[18:8];
    m2_12_q  <= q_11_q[18:0] * 13'(btpc_pkg::PC2);
    t_12_q   <= t_11_q;
    zd_12_q  <= zd_11_q;

    x1c_13_q <= prod13[33:16];
    x2c_13_q <= m2_12_q[31:16];
    p19_13_q <= p19_12_q;
    big_13_q <= big_12_q;
    t_13_q   <= t_12_q;
    zd_13_q  <= zd_12_q;

    corr_14_q <= $signed({2'b0, x1c_13_q}) - $signed({4'b0, x2c_13_q})
                 + 20'(btpc_pkg::PC3);
    p19_14_q  <= p19_13_q;
    big_14_q  <= big_13_q;
    t_14_q    <= t_13_q;
    zd_14_q   <= zd_13_q;

    res_q.temperature_tenths <= zd_14_q ? '0 : t_14_q;
    res_q.pressure_pa        <= zd_14_q ? '0 : p_fin;
    res_q.divide_error       <= zd_14_q;
  end

  assign res_vld_o = v15_q;
  assign res_o     = res_q;

endmodule

@@ hw/rtl/baro_temp_pressure_compensation_top.sv @@
// barometric temperature and pressure compensation
// input: a word (raw temperature, raw pressure) is taken on a clock edge with
// start high and busy low; configuration holds the ten calibration
// coefficients in five 32-bit registers, written through cfg_we_i, cfg_idx_i
// and cfg_data_i at any edge with the write enable high
// output: each result word is shown on result_o for one cycle with
// result_valid_o high; the receiver cannot stall
// throughput: one word per cycle while busy is low; the front stages feed a
// short queue that the back pipeline drains every cycle, and the back
// pipeline never stops
// the back pipeline holds two pipelined restoring dividers, one bit per stage,
// of 27 and 32 stages
// busy rises when the queue holds FIFO_DEPTH - 2 entries; it holds one at most
// reset clears all calibration registers, the queue and every valid bit
module baro_temp_pressure_compensation_top #(
  parameter int unsigned FIFO_DEPTH = btpc_pkg::FifoDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  btpc_pkg::item_t                item_i,
  input  logic                           cfg_we_i,
  input  logic [btpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [btpc_pkg::CfgW-1:0]      cfg_data_i,
  output logic                           result_valid_o,
  output btpc_pkg::result_t              result_o
);

  logic [btpc_pkg::CfgW-1:0] cfg_q [btpc_pkg::NumCfg];
  btpc_pkg::cal_t            cal;
  btpc_pkg::job_word_t       push, pop;
  logic                      accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < btpc_pkg::NumCfg; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (btpc_pkg::cfg_idx_e'(cfg_idx_i))
        btpc_pkg::CFG_AC1_AC2: cfg_q[btpc_pkg::CFG_AC1_AC2] <= cfg_data_i;
        btpc_pkg::CFG_AC3_AC4: cfg_q[btpc_pkg::CFG_AC3_AC4] <= cfg_data_i;
        btpc_pkg::CFG_AC5_AC6: cfg_q[btpc_pkg::CFG_AC5_AC6] <= cfg_data_i;
        btpc_pkg::CFG_B1_B2:   cfg_q[btpc_pkg::CFG_B1_B2]   <= cfg_data_i;
        btpc_pkg::CFG_MC_MD:   cfg_q[btpc_pkg::CFG_MC_MD]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.ac1 = $signed(cfg_q[btpc_pkg::CFG_AC1_AC2][31:16]);
    cal.ac2 = $signed(cfg_q[btpc_pkg::CFG_AC1_AC2][15:0]);
    cal.ac3 = $signed(cfg_q[btpc_pkg::CFG_AC3_AC4][31:16]);
    cal.ac4 = cfg_q[btpc_pkg::CFG_AC3_AC4][15:0];
    cal.ac5 = cfg_q[btpc_pkg::CFG_AC5_AC6][31:16];
    cal.ac6 = cfg_q[btpc_pkg::CFG_AC5_AC6][15:0];
    cal.b1  = $signed(cfg_q[btpc_pkg::CFG_B1_B2][31:16]);
    cal.b2  = $signed(cfg_q[btpc_pkg::CFG_B1_B2][15:0]);
    cal.mc  = $signed(cfg_q[btpc_pkg::CFG_MC_MD][31:16]);
    cal.md  = $signed(cfg_q[btpc_pkg::CFG_MC_MD][15:0]);
  end

  assign accept = start & ~busy;

  btpc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .cal_i    (cal),
    .push_o   (push)
  );

  btpc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_o  (pop),
    .busy_o (busy)
  );

  btpc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cal_i     (cal),
    .pop_i     (pop),
    .res_vld_o (result_valid_o),
    .res_o     (result_o)
  );

endmodule
